// ===== rtl/core/tcce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg: shared types, codes and microcode for the text console engine
// Holds request and character codes, the control word layout and the
// read-only step program that the sequencer runs.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BLANK     = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

  localparam logic [3:0] P_RST_INIT  = 4'd0;
  localparam logic [3:0] P_RST_SWEEP = 4'd1;
  localparam logic [3:0] P_FETCH     = 4'd2;
  localparam logic [3:0] P_PUT       = 4'd3;
  localparam logic [3:0] P_NL        = 4'd4;
  localparam logic [3:0] P_CR        = 4'd5;
  localparam logic [3:0] P_BS_MOVE   = 4'd6;
  localparam logic [3:0] P_BS_BLANK  = 4'd7;
  localparam logic [3:0] P_TAB_DIV   = 4'd8;
  localparam logic [3:0] P_TAB_SET   = 4'd9;
  localparam logic [3:0] P_SETCUR    = 4'd10;
  localparam logic [3:0] P_CLR_INIT  = 4'd11;
  localparam logic [3:0] P_SWEEP     = 4'd12;
  localparam logic [3:0] P_READ      = 4'd13;
  localparam logic [3:0] P_READ_DONE = 4'd14;

  typedef enum logic [3:0] {
    OP_RST_INIT,
    OP_SWEEP,
    OP_FETCH,
    OP_PUT,
    OP_NL,
    OP_CR,
    OP_BS_MOVE,
    OP_BS_BLANK,
    OP_TAB_DIV,
    OP_TAB_SET,
    OP_SETCUR,
    OP_CLR_INIT,
    OP_READ,
    OP_READ_DONE
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_DISPATCH,
    C_COL_LAST,
    C_ROW_LAST,
    C_TAB_WRAP,
    C_SWEEP_MORE
  } cond_t;

  typedef struct packed {
    op_t        op;
    cond_t      cond;
    logic [3:0] target;
    logic       last;
  } ucode_word_t;

  typedef struct packed {
    logic col_last;
    logic row_last;
    logic tab_wrap;
    logic sweep_more;
    logic out_busy;
  } flags_t;

  typedef struct packed {
    op_t  op;
    logic go;
    logic emit;
  } ctrl_t;

  function automatic ucode_word_t ucode(input logic [3:0] pc);
    ucode_word_t w;
    unique case (pc)
      P_RST_INIT:  w = '{OP_RST_INIT,  C_NONE,       P_FETCH,     1'b0};
      P_RST_SWEEP: w = '{OP_SWEEP,     C_SWEEP_MORE, P_RST_SWEEP, 1'b0};
      P_FETCH:     w = '{OP_FETCH,     C_DISPATCH,   P_FETCH,     1'b0};
      P_PUT:       w = '{OP_PUT,       C_COL_LAST,   P_NL,        1'b1};
      P_NL:        w = '{OP_NL,        C_ROW_LAST,   P_SWEEP,     1'b1};
      P_CR:        w = '{OP_CR,        C_NONE,       P_FETCH,     1'b1};
      P_BS_MOVE:   w = '{OP_BS_MOVE,   C_NONE,       P_FETCH,     1'b0};
      P_BS_BLANK:  w = '{OP_BS_BLANK,  C_NONE,       P_FETCH,     1'b1};
      P_TAB_DIV:   w = '{OP_TAB_DIV,   C_NONE,       P_FETCH,     1'b0};
      P_TAB_SET:   w = '{OP_TAB_SET,   C_TAB_WRAP,   P_NL,        1'b1};
      P_SETCUR:    w = '{OP_SETCUR,    C_NONE,       P_FETCH,     1'b1};
      P_CLR_INIT:  w = '{OP_CLR_INIT,  C_NONE,       P_FETCH,     1'b0};
      P_SWEEP:     w = '{OP_SWEEP,     C_SWEEP_MORE, P_SWEEP,     1'b1};
      P_READ:      w = '{OP_READ,      C_NONE,       P_FETCH,     1'b0};
      P_READ_DONE: w = '{OP_READ_DONE, C_NONE,       P_FETCH,     1'b1};
      default:     w = '{OP_FETCH,     C_DISPATCH,   P_FETCH,     1'b0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tcce_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tcce_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_seq: microcode sequencer
// Step counter over the control program, request dispatch, conditional
// jumps and the hold that keeps a finishing step until the result slot frees.
// ----------------------------------------------------------------------------
module tcce_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      req_type,
  input  wire logic [7:0]      char_code,
  input  wire tcce_pkg::flags_t flags,
  output tcce_pkg::ctrl_t      ctrl
);
  import tcce_pkg::*;

  logic [3:0]  pc;
  logic [3:0]  pc_next;
  ucode_word_t word;
  logic        hit;
  logic        fetch;
  logic        emit_req;
  logic        go;

  function automatic logic [3:0] dispatch(input logic [1:0] req, input logic [7:0] ch);
    logic [3:0] t;
    unique case (req)
      REQ_PUT: begin
        unique case (ch)
          CH_NEWLINE:   t = P_NL;
          CH_RETURN:    t = P_CR;
          CH_BACKSPACE: t = P_BS_MOVE;
          CH_TAB:       t = P_TAB_DIV;
          default:      t = P_PUT;
        endcase
      end
      REQ_SET:   t = P_SETCUR;
      REQ_CLEAR: t = P_CLR_INIT;
      REQ_READ:  t = P_READ;
      default:   t = P_FETCH;
    endcase
    return t;
  endfunction

  always_comb begin
    word = ucode(pc);
    unique case (word.cond)
      C_NONE:       hit = 1'b0;
      C_DISPATCH:   hit = 1'b0;
      C_COL_LAST:   hit = flags.col_last;
      C_ROW_LAST:   hit = flags.row_last;
      C_TAB_WRAP:   hit = flags.tab_wrap;
      C_SWEEP_MORE: hit = flags.sweep_more;
      default:      hit = 1'b0;
    endcase
    fetch    = (word.cond == C_DISPATCH);
    in_ready = fetch;
    emit_req = word.last && !hit;
    go       = fetch ? in_valid : !(emit_req && flags.out_busy);
    pc_next  = pc;
    if (go) begin
      priority if (fetch) begin
        pc_next = dispatch(req_type, char_code);
      end else if (hit) begin
        pc_next = word.target;
      end else if (word.last) begin
        pc_next = P_FETCH;
      end else begin
        pc_next = pc + 4'd1;
      end
    end
    ctrl.op   = word.op;
    ctrl.go   = go;
    ctrl.emit = go && emit_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= P_RST_INIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/text_console_char_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_engine: text-mode console character engine
// Cell store of ROWS x COLUMNS characters with attributes and a cursor,
// driven by a microcoded sequencer over a single cell RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request: put character, set
//   cursor, clear screen or read cell. Output channel (out_valid/out_ready)
//   returns one result per request: cursor after the step, cell read, flags.
//   Config channel (cfg_valid/cfg_ready, always ready) writes fg_color (0)
//   and bg_color (1); write it only while the engine is idle.
//   Backspace moves the cursor, then blanks the cell; tab divides, then sets
//   the column; read issues the RAM read, then returns the data. A put at the
//   line end and a tab past the line end go on to a newline; a scroll adds
//   COLUMNS blank writes, one cell per cycle through the RAM write port, the
//   last held while the receiver stalls; clear blanks all ROWS*COLUMNS cells.
//   After reset a clearing pass over all ROWS*COLUMNS cells fills the store
//   with blanks (attribute 0x0F); in_ready stays low until it ends.
//   One request is in flight at a time; a result waiting in the output
//   register does not block the next input transfer, but a finishing step
//   holds while the receiver stalls.
// ----------------------------------------------------------------------------
module text_console_char_engine #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     req_type,
  input  wire logic [7:0]                     char_code,
  input  wire logic [4:0]                     row_sel,
  input  wire logic [6:0]                     col_sel,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [4:0]                     cursor_row,
  output logic      [6:0]                     cursor_col,
  output logic      [10:0]                    cursor_pos,
  output logic      [7:0]                     cell_char,
  output logic      [7:0]                     cell_attr,
  output logic                                scrolled,
  output logic                                rejected,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [3:0]                     cfg_data
);
  import tcce_pkg::*;

  localparam int DEPTH     = ROWS * COLUMNS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int TAB_K     = 16;
  localparam int TAB_RECIP = (2 ** TAB_K + TAB_STOP - 1) / TAB_STOP;

  flags_t flags;
  ctrl_t  ctrl;

  logic [4:0]        cur_row, cur_row_next;
  logic [6:0]        cur_col, cur_col_next;
  logic [4:0]        top_line, top_line_next;
  logic [3:0]        fg_color, bg_color;
  logic [7:0]        item_char, item_char_next;
  logic [4:0]        item_row, item_row_next;
  logic [6:0]        item_col, item_col_next;
  logic [6:0]        tab_q, tab_q_next;
  logic [ADDR_W-1:0] sweep_addr, sweep_addr_next;
  logic [ADDR_W-1:0] sweep_left, sweep_left_next;
  logic [7:0]        blank_attr, blank_attr_next;
  logic              scrolled_f, scrolled_f_next;
  logic              rejected_f, rejected_f_next;

  logic [7:0]        attr;
  logic [4:0]        top_inc;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] item_addr;
  logic              item_off;
  logic [23:0]       tab_prod;
  logic [11:0]       tab_next;
  logic [11:0]       pos_full;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              rd_en;
  logic [15:0]       rd_data;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0] top,
                                                  input logic [4:0] r,
                                                  input logic [6:0] c);
    logic [5:0] sum;
    logic [4:0] phys;
    sum  = {1'b0, top} + {1'b0, r};
    phys = (sum >= 6'(ROWS)) ? 5'(sum - 6'(ROWS)) : sum[4:0];
    return ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  tcce_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .char_code (char_code),
    .flags     (flags),
    .ctrl      (ctrl)
  );

  tcce_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (item_addr),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;
  assign attr      = {bg_color, fg_color};
  assign top_inc   = (top_line == 5'(ROWS - 1)) ? 5'd0 : top_line + 5'd1;
  assign cur_addr  = cell_addr(top_line, cur_row, cur_col);
  assign item_addr = cell_addr(top_line, item_row, item_col);
  assign item_off  = ({1'b0, item_row} >= 6'(ROWS)) || ({1'b0, item_col} >= 8'(COLUMNS));
  assign tab_prod  = 24'(cur_col) * 24'(TAB_RECIP);
  assign tab_next  = 12'({5'd0, tab_q} + 12'd1) * 12'(TAB_STOP);

  assign flags.col_last   = (cur_col == 7'(COLUMNS - 1));
  assign flags.row_last   = (cur_row == 5'(ROWS - 1));
  assign flags.tab_wrap   = (tab_next >= 12'(COLUMNS));
  assign flags.sweep_more = (sweep_left != '0);
  assign flags.out_busy   = out_valid && !out_ready;

  always_comb begin
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    top_line_next   = top_line;
    item_char_next  = item_char;
    item_row_next   = item_row;
    item_col_next   = item_col;
    tab_q_next      = tab_q;
    sweep_addr_next = sweep_addr;
    sweep_left_next = sweep_left;
    blank_attr_next = blank_attr;
    scrolled_f_next = scrolled_f;
    rejected_f_next = rejected_f;
    wr_en           = 1'b0;
    wr_addr         = cur_addr;
    wr_data         = {attr, CH_BLANK};
    rd_en           = 1'b0;
    if (ctrl.go) begin
      unique case (ctrl.op)
        OP_RST_INIT: begin
          sweep_addr_next = '0;
          sweep_left_next = ADDR_W'(DEPTH - 1);
          blank_attr_next = RESET_ATTR;
        end
        OP_SWEEP: begin
          wr_en           = 1'b1;
          wr_addr         = sweep_addr;
          wr_data         = {blank_attr, CH_BLANK};
          sweep_addr_next = sweep_addr + ADDR_W'(1);
          sweep_left_next = sweep_left - ADDR_W'(1);
        end
        OP_FETCH: begin
          item_char_next  = char_code;
          item_row_next   = row_sel;
          item_col_next   = col_sel;
          scrolled_f_next = 1'b0;
          rejected_f_next = 1'b0;
        end
        OP_PUT: begin
          wr_en   = 1'b1;
          wr_data = {attr, item_char};
          if (!flags.col_last) begin
            cur_col_next = cur_col + 7'd1;
          end
        end
        OP_NL: begin
          cur_col_next = 7'd0;
          if (!flags.row_last) begin
            cur_row_next = cur_row + 5'd1;
          end else begin
            sweep_addr_next = ADDR_W'(top_line) * ADDR_W'(COLUMNS);
            sweep_left_next = ADDR_W'(COLUMNS - 1);
            blank_attr_next = attr;
            top_line_next   = top_inc;
            scrolled_f_next = 1'b1;
          end
        end
        OP_CR: begin
          cur_col_next = 7'd0;
        end
        OP_BS_MOVE: begin
          if (cur_col != 7'd0) begin
            cur_col_next = cur_col - 7'd1;
          end else if (cur_row != 5'd0) begin
            cur_col_next = 7'(COLUMNS - 1);
            cur_row_next = cur_row - 5'd1;
          end
        end
        OP_BS_BLANK: begin
          wr_en = 1'b1;
        end
        OP_TAB_DIV: begin
          tab_q_next = tab_prod[TAB_K+6:TAB_K];
        end
        OP_TAB_SET: begin
          if (!flags.tab_wrap) begin
            cur_col_next = tab_next[6:0];
          end
        end
        OP_SETCUR: begin
          if (item_off) begin
            rejected_f_next = 1'b1;
          end else begin
            cur_row_next = item_row;
            cur_col_next = item_col;
          end
        end
        OP_CLR_INIT: begin
          sweep_addr_next = '0;
          sweep_left_next = ADDR_W'(DEPTH - 1);
          blank_attr_next = attr;
          top_line_next   = 5'd0;
          cur_row_next    = 5'd0;
          cur_col_next    = 7'd0;
        end
        OP_READ: begin
          if (item_off) begin
            rejected_f_next = 1'b1;
          end else begin
            rd_en = 1'b1;
          end
        end
        OP_READ_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign pos_full = 12'(cur_row_next) * 12'(COLUMNS) + 12'(cur_col_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row   <= 5'd0;
      cur_col   <= 7'd0;
      top_line  <= 5'd0;
      fg_color  <= 4'd15;
      bg_color  <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      top_line <= top_line_next;
      if (cfg_valid && cfg_ready) begin
        priority if (cfg_index == CFG_FG) begin
          fg_color <= cfg_data;
        end else if (cfg_index == CFG_BG) begin
          bg_color <= cfg_data;
        end
      end
      if (ctrl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_char  <= item_char_next;
    item_row   <= item_row_next;
    item_col   <= item_col_next;
    tab_q      <= tab_q_next;
    sweep_addr <= sweep_addr_next;
    sweep_left <= sweep_left_next;
    blank_attr <= blank_attr_next;
    scrolled_f <= scrolled_f_next;
    rejected_f <= rejected_f_next;
    if (ctrl.emit) begin
      cursor_row <= cur_row_next;
      cursor_col <= cur_col_next;
      cursor_pos <= pos_full[10:0];
      scrolled   <= scrolled_f_next;
      rejected   <= rejected_f_next;
      if (ctrl.op == OP_READ_DONE && !rejected_f) begin
        cell_char <= rd_data[7:0];
        cell_attr <= rd_data[15:8];
      end else begin
        cell_char <= 8'd0;
        cell_attr <= 8'd0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tcce_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_checker: port-level checks for the text console engine
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module tcce_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [4:0]  cursor_row,
  input wire logic [6:0]  cursor_col,
  input wire logic [10:0] cursor_pos,
  input wire logic [7:0]  cell_char,
  input wire logic [7:0]  cell_attr,
  input wire logic        scrolled,
  input wire logic        rejected
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_pos) && $stable(cell_char)
      && $stable(cell_attr) && $stable(scrolled) && $stable(rejected))
    else $error("stalled result changed");

  a_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_pos == 11'(12'(cursor_row) * 12'(COLUMNS) + 12'(cursor_col)))
    else $error("cursor position does not match row and column");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> cell_char == 8'd0 && cell_attr == 8'd0 && !scrolled)
    else $error("rejected result carries cell data or scroll");

  a_scroll: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> cursor_row == 5'(ROWS - 1) && cursor_col == 7'd0)
    else $error("scroll left cursor off the bottom line start");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer accepted while request in flight");

endmodule

bind text_console_char_engine tcce_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcce_checker (.*);
`default_nettype wire
